// ===== hdl/ntre_pkg.sv =====
// shared types and constants for the ndef text record extractor
package ntre_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 10;
    localparam int BUFSZ_W   = 11;
    localparam int PAYLEN_W  = 32;
    localparam int LEFT_W    = 3;
    localparam int KIND_W    = 2;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [BUFSZ_W-1:0] BUFSZ_RESET = 11'd64;
    localparam logic [BUFSZ_W-1:0] BUFSZ_MAX   = 11'd1024;

    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

    localparam logic [BYTE_W-1:0] TLV_NULL       = 8'h00;
    localparam logic [BYTE_W-1:0] TLV_LOCK_CTRL  = 8'h01;
    localparam logic [BYTE_W-1:0] TLV_MEM_CTRL   = 8'h02;
    localparam logic [BYTE_W-1:0] TLV_NDEF       = 8'h03;
    localparam logic [BYTE_W-1:0] TLV_PROPRIETARY = 8'hfd;
    localparam logic [BYTE_W-1:0] TLV_TERMINATOR = 8'hfe;

    localparam logic [BYTE_W-1:0] CTRL_SKIP_LEN  = 8'd4;
    localparam logic [2:0]        TNF_WELL_KNOWN = 3'd1;
    localparam int                HDR_SR_BIT     = 4;
    localparam int                HDR_IL_BIT     = 3;
    localparam int                STATUS_UTF16_BIT = 7;
    localparam logic [BYTE_W-1:0] TYPE_TEXT      = 8'h54;
    localparam logic [LEFT_W-1:0] PAYLEN_SHORT   = 3'd1;
    localparam logic [LEFT_W-1:0] PAYLEN_LONG    = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT       = 2'd0,
        KIND_TERMINATOR = 2'd1,
        KIND_ERROR      = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_TAG      = 4'd0,
        PH_SKIP     = 4'd1,
        PH_PROP_LEN = 4'd2,
        PH_NDEF_LEN = 4'd3,
        PH_HEADER   = 4'd4,
        PH_TYPE_LEN = 4'd5,
        PH_PAYLEN   = 4'd6,
        PH_IDLEN    = 4'd7,
        PH_TYPE     = 4'd8,
        PH_ID       = 4'd9,
        PH_STATUS   = 4'd10,
        PH_LANG     = 4'd11,
        PH_TEXT     = 4'd12,
        PH_REST     = 4'd13,
        PH_DONE     = 4'd14
    } phase_t;

    typedef struct packed {
        logic                valid;
        kind_t               kind;
        logic [BYTE_W-1:0]   char_value;
        logic [COUNT_W-1:0]  text_length;
        logic                last;
    } result_t;

endpackage

// ===== hdl/ndef_text_record_extractor.sv =====
// top level: input register, parser, result register and apb register port
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_tag_byte, s_first
//  m_        out        m_valid/m_ready    m_kind, m_char_value, m_text_length, m_last
//  apb       in/out     psel/penable       paddr, pwdata, prdata (buffer_size at 0x0)
//
// one byte per cycle unless the output stalls; a byte is held in the input register
// and its result, if any, enters the result register as the byte leaves it
// the parse state updates in the same cycle the byte leaves the input register
// a stalled result holds the input register, which then holds s_ready low
// reset is synchronous and restores buffer_size to 64 and the tag-expect state
module ndef_text_record_extractor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ntre_pkg::BYTE_W-1:0]    s_tag_byte,
    input  logic                           s_first,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ntre_pkg::KIND_W-1:0]    m_kind,
    output logic [ntre_pkg::BYTE_W-1:0]    m_char_value,
    output logic [ntre_pkg::COUNT_W-1:0]   m_text_length,
    output logic                           m_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntre_pkg::ADDR_W-1:0]    paddr,
    input  logic [ntre_pkg::DATA_W-1:0]    pwdata,
    output logic [ntre_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import ntre_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_first_reg;
    logic [BUFSZ_W-1:0]  buffer_size_reg;
    logic                out_free;
    logic                advance;
    logic                cfg_write;
    result_t             result;

    assign out_free  = !m_valid || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || advance;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_tag_byte;
            in_first_reg <= s_first;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= BUFSZ_RESET;
        end else if (cfg_write) begin
            buffer_size_reg <= pwdata[BUFSZ_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BUFFER_SIZE) begin
            prdata = {{(DATA_W-BUFSZ_W){1'b0}}, buffer_size_reg};
        end
    end

    ntre_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .tag_byte    (in_byte_reg),
        .first       (in_first_reg),
        .buffer_size (buffer_size_reg),
        .result      (result)
    );

    ntre_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .result        (result),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_char_value  (m_char_value),
        .m_text_length (m_text_length),
        .m_last        (m_last)
    );

endmodule

// ===== hdl/ntre_parser.sv =====
// tlv walker and text record decoder: parse state and one-byte step logic
module ntre_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [ntre_pkg::BYTE_W-1:0]   tag_byte,
    input  logic                          first,
    input  logic [ntre_pkg::BUFSZ_W-1:0]  buffer_size,
    output ntre_pkg::result_t             result
);
    import ntre_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [BYTE_W-1:0]    skip_reg, skip_next;
    logic [BYTE_W-1:0]    tlv_reg, tlv_next;
    logic                 sr_reg, sr_next;
    logic                 il_reg, il_next;
    logic [BYTE_W-1:0]    type_len_reg, type_len_next;
    logic [BYTE_W-1:0]    id_len_reg, id_len_next;
    logic [PAYLEN_W-1:0]  pay_len_reg, pay_len_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic                 is_text_reg, is_text_next;
    logic [PAYLEN_W-1:0]  copy_reg, copy_next;
    logic [COUNT_W-1:0]   emitted_reg, emitted_next;

    phase_t               cur_phase;
    logic [BYTE_W-1:0]    cur_skip, cur_tlv, cur_type_len, cur_id_len;
    logic                 cur_sr, cur_il, cur_is_text;
    logic [PAYLEN_W-1:0]  cur_pay_len, cur_copy;
    logic [LEFT_W-1:0]    cur_left;
    logic [COUNT_W-1:0]   cur_emitted;
    logic                 in_record;
    logic [BUFSZ_W-1:0]   cap;
    logic [BUFSZ_W-1:0]   budget_full;
    logic [COUNT_W-1:0]   budget;
    logic [5:0]           lang_len;
    logic [PAYLEN_W-1:0]  lang_ext;

    // budget is min(buffer_size, 1024) - 1, zero when buffer_size is zero
    always_comb begin
        cap         = (buffer_size > BUFSZ_MAX) ? BUFSZ_MAX : buffer_size;
        budget_full = (cap == '0) ? '0 : cap - 11'd1;
        budget      = budget_full[COUNT_W-1:0];
    end

    always_comb begin
        cur_phase    = first ? PH_TAG : phase_reg;
        cur_skip     = first ? '0 : skip_reg;
        cur_tlv      = first ? '0 : tlv_reg;
        cur_sr       = first ? 1'b0 : sr_reg;
        cur_il       = first ? 1'b0 : il_reg;
        cur_type_len = first ? '0 : type_len_reg;
        cur_id_len   = first ? '0 : id_len_reg;
        cur_pay_len  = first ? '0 : pay_len_reg;
        cur_left     = first ? '0 : left_reg;
        cur_is_text  = first ? 1'b0 : is_text_reg;
        cur_copy     = first ? '0 : copy_reg;
        cur_emitted  = first ? '0 : emitted_reg;

        phase_next    = cur_phase;
        skip_next     = cur_skip;
        tlv_next      = cur_tlv;
        sr_next       = cur_sr;
        il_next       = cur_il;
        type_len_next = cur_type_len;
        id_len_next   = cur_id_len;
        pay_len_next  = cur_pay_len;
        left_next     = cur_left;
        is_text_next  = cur_is_text;
        copy_next     = cur_copy;
        emitted_next  = cur_emitted;

        result.valid       = 1'b0;
        result.kind        = KIND_TEXT;
        result.char_value  = '0;
        result.text_length = cur_emitted;
        result.last        = 1'b0;

        lang_len = tag_byte[5:0];
        lang_ext = {{(PAYLEN_W-6){1'b0}}, lang_len};

        in_record = (cur_phase >= PH_HEADER) && (cur_phase <= PH_REST);
        if (in_record && (cur_tlv != '0)) begin
            tlv_next = cur_tlv - 8'd1;
        end

        case (cur_phase)
            PH_TAG: begin
                if (tag_byte == TLV_NULL) begin
                    phase_next = PH_TAG;
                end else if (tag_byte == TLV_LOCK_CTRL || tag_byte == TLV_MEM_CTRL) begin
                    skip_next  = CTRL_SKIP_LEN;
                    phase_next = PH_SKIP;
                end else if (tag_byte == TLV_NDEF) begin
                    phase_next = PH_NDEF_LEN;
                end else if (tag_byte == TLV_PROPRIETARY) begin
                    phase_next = PH_PROP_LEN;
                end else if (tag_byte == TLV_TERMINATOR) begin
                    phase_next   = PH_DONE;
                    result.valid = 1'b1;
                    result.kind  = KIND_TERMINATOR;
                    result.last  = 1'b1;
                end else begin
                    phase_next   = PH_DONE;
                    result.valid = 1'b1;
                    result.kind  = KIND_ERROR;
                    result.last  = 1'b1;
                end
            end
            PH_SKIP: begin
                if (cur_skip != '0) begin
                    skip_next = cur_skip - 8'd1;
                end
                if (skip_next == '0) begin
                    phase_next = PH_TAG;
                end
            end
            PH_PROP_LEN: begin
                skip_next  = tag_byte;
                phase_next = (tag_byte == '0) ? PH_TAG : PH_SKIP;
            end
            PH_NDEF_LEN: begin
                tlv_next   = tag_byte;
                phase_next = (tag_byte == '0) ? PH_TAG : PH_HEADER;
            end
            PH_HEADER: begin
                sr_next      = tag_byte[HDR_SR_BIT];
                il_next      = tag_byte[HDR_IL_BIT];
                id_len_next  = '0;
                pay_len_next = '0;
                phase_next   = (tag_byte[2:0] == TNF_WELL_KNOWN) ? PH_TYPE_LEN : PH_REST;
            end
            PH_TYPE_LEN: begin
                type_len_next = tag_byte;
                left_next     = cur_sr ? PAYLEN_SHORT : PAYLEN_LONG;
                phase_next    = PH_PAYLEN;
            end
            PH_PAYLEN: begin
                pay_len_next = {cur_pay_len[PAYLEN_W-BYTE_W-1:0], tag_byte};
                if (cur_left != '0) begin
                    left_next = cur_left - 3'd1;
                end
                if (left_next == '0) begin
                    if (cur_il) begin
                        phase_next = PH_IDLEN;
                    end else begin
                        is_text_next = 1'b0;
                        if (cur_type_len == '0) begin
                            phase_next = PH_REST;
                        end else begin
                            skip_next  = cur_type_len;
                            phase_next = PH_TYPE;
                        end
                    end
                end
            end
            PH_IDLEN: begin
                id_len_next  = tag_byte;
                is_text_next = 1'b0;
                if (cur_type_len == '0) begin
                    phase_next = PH_REST;
                end else begin
                    skip_next  = cur_type_len;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (cur_skip == cur_type_len) begin
                    is_text_next = (cur_type_len == 8'd1) && (tag_byte == TYPE_TEXT);
                end
                if (cur_skip != '0) begin
                    skip_next = cur_skip - 8'd1;
                end
                if (skip_next == '0) begin
                    if (!is_text_next) begin
                        phase_next = PH_REST;
                    end else if (cur_id_len != '0) begin
                        skip_next  = cur_id_len;
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_ID: begin
                if (cur_skip != '0) begin
                    skip_next = cur_skip - 8'd1;
                end
                if (skip_next == '0) begin
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (tag_byte[STATUS_UTF16_BIT]) begin
                    phase_next = PH_REST;
                end else begin
                    copy_next = (cur_pay_len > lang_ext) ?
                                (cur_pay_len - lang_ext - 32'd1) : '0;
                    if (lang_len != '0) begin
                        skip_next  = {2'b00, lang_len};
                        phase_next = PH_LANG;
                    end else begin
                        phase_next = (copy_next == '0) ? PH_REST : PH_TEXT;
                    end
                end
            end
            PH_LANG: begin
                if (cur_skip != '0) begin
                    skip_next = cur_skip - 8'd1;
                end
                if (skip_next == '0) begin
                    phase_next = (cur_copy == '0) ? PH_REST : PH_TEXT;
                end
            end
            PH_TEXT: begin
                if (cur_copy != '0) begin
                    copy_next = cur_copy - 32'd1;
                    if (cur_emitted < budget) begin
                        emitted_next       = cur_emitted + 10'd1;
                        result.valid       = 1'b1;
                        result.kind        = KIND_TEXT;
                        result.char_value  = tag_byte;
                        result.text_length = emitted_next;
                    end
                end
                if (copy_next == '0) begin
                    phase_next = PH_REST;
                end
            end
            PH_REST: begin
                phase_next = PH_REST;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // running out of ndef tlv length always returns to tag parsing
        if (in_record && (tlv_next == '0)) begin
            phase_next = PH_TAG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG;
            skip_reg     <= '0;
            tlv_reg      <= '0;
            sr_reg       <= 1'b0;
            il_reg       <= 1'b0;
            type_len_reg <= '0;
            id_len_reg   <= '0;
            pay_len_reg  <= '0;
            left_reg     <= '0;
            is_text_reg  <= 1'b0;
            copy_reg     <= '0;
            emitted_reg  <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            tlv_reg      <= tlv_next;
            sr_reg       <= sr_next;
            il_reg       <= il_next;
            type_len_reg <= type_len_next;
            id_len_reg   <= id_len_next;
            pay_len_reg  <= pay_len_next;
            left_reg     <= left_next;
            is_text_reg  <= is_text_next;
            copy_reg     <= copy_next;
            emitted_reg  <= emitted_next;
        end
    end

endmodule

// ===== hdl/ntre_out_reg.sv =====
// result register on the output channel
module ntre_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  ntre_pkg::result_t              result,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [ntre_pkg::KIND_W-1:0]    m_kind,
    output logic [ntre_pkg::BYTE_W-1:0]    m_char_value,
    output logic [ntre_pkg::COUNT_W-1:0]   m_text_length,
    output logic                           m_last
);
    import ntre_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && result.valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = data_reg.kind;
    assign m_char_value  = data_reg.char_value;
    assign m_text_length = data_reg.text_length;
    assign m_last        = data_reg.last;

endmodule
